@@ design/fpa_pkg.sv @@
// shared types, op codes and saturation helper for the fixed-point alu
`timescale 1ns / 1ps
`default_nettype none
package fpa_pkg;

    localparam int FRAC_BITS_DEF = 8;
    localparam int DIV_STEPS     = 32;

    typedef enum logic [3:0] {
        OP_ADD      = 4'd0,
        OP_SUB      = 4'd1,
        OP_MUL      = 4'd2,
        OP_DIV      = 4'd3,
        OP_EQ       = 4'd4,
        OP_NE       = 4'd5,
        OP_GE       = 4'd6,
        OP_LE       = 4'd7,
        OP_GT       = 4'd8,
        OP_LT       = 4'd9,
        OP_INC      = 4'd10,
        OP_DEC      = 4'd11,
        OP_TO_INT   = 4'd12,
        OP_FROM_INT = 4'd13
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_OVF  = 2'd1,
        ST_DIV0 = 2'd2
    } status_t;

    localparam logic [31:0] SAT_MAX = 32'h7fff_ffff;
    localparam logic [31:0] SAT_MIN = 32'h8000_0000;

    // one item as it travels down the pipeline
    typedef struct packed {
        op_t                kind;
        logic [31:0]        simple_res;
        logic               cmp;
        status_t            status;
        logic signed [63:0] prod;
        logic [32:0]        rem;
        logic [31:0]        dvs;
        logic [31:0]        num_lo;
        logic [31:0]        quo;
        logic               neg;
        logic               dovf;
    } pipe_t;

    typedef struct packed {
        logic        ovf;
        logic [31:0] value;
    } sat_t;

    // apply sign to a magnitude and saturate to 32 bits
    function automatic sat_t sat_mag(input logic neg, input logic [63:0] mag);
        sat_t r;
        r.ovf   = 1'b0;
        r.value = 32'd0;
        if (!neg) begin
            if (mag > 64'h0000_0000_7fff_ffff) begin
                r.ovf   = 1'b1;
                r.value = SAT_MAX;
            end else begin
                r.value = mag[31:0];
            end
        end else begin
            if (mag > 64'h0000_0000_8000_0000) begin
                r.ovf   = 1'b1;
                r.value = SAT_MIN;
            end else begin
                r.value = 32'd0 - mag[31:0];
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

@@ design/fpa_prep.sv @@
// first stage: decode, simple ops, product and divider setup
`timescale 1ns / 1ps
`default_nettype none
module fpa_prep #(
    parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
    input  wire logic [3:0]  op_in,
    input  wire logic [31:0] a_in,
    input  wire logic [31:0] b_in,
    output fpa_pkg::pipe_t   item
);
    import fpa_pkg::*;

    logic signed [31:0] a_s;
    logic signed [31:0] b_s;
    logic [31:0]        a_mag;
    logic [31:0]        b_mag;
    logic [63:0]        num;
    logic [32:0]        sum;
    logic [32:0]        diff;
    logic [32:0]        incv;
    logic [32:0]        decv;
    logic signed [63:0] shl;
    op_t                op;

    assign a_s   = signed'(a_in);
    assign b_s   = signed'(b_in);
    assign a_mag = a_in[31] ? 32'd0 - a_in : a_in;
    assign b_mag = b_in[31] ? 32'd0 - b_in : b_in;
    assign num   = {32'd0, a_mag} << FRAC_BITS;
    assign sum   = {a_in[31], a_in} + {b_in[31], b_in};
    assign diff  = {a_in[31], a_in} - {b_in[31], b_in};
    assign incv  = {a_in[31], a_in} + 33'd1;
    assign decv  = {a_in[31], a_in} - 33'd1;
    assign shl   = 64'(a_s) <<< FRAC_BITS;
    assign op    = op_t'(op_in);

    // per-op result of everything that finishes here
    always_comb begin
        item            = '0;
        item.kind       = op;
        item.prod       = 64'(a_s) * 64'(b_s);
        item.dvs        = b_mag;
        item.num_lo     = num[31:0];
        item.rem        = {1'b0, num[63:32]};
        item.dovf       = num[63:32] >= b_mag;
        item.neg        = a_in[31] ^ b_in[31];
        item.simple_res = 32'd0;
        item.cmp        = 1'b0;
        item.status     = ST_OK;
        unique case (op)
            OP_ADD:  begin
                item.simple_res = (sum[32] != sum[31]) ? (sum[32] ? SAT_MIN : SAT_MAX) : sum[31:0];
                item.status     = (sum[32] != sum[31]) ? ST_OVF : ST_OK;
            end
            OP_SUB:  begin
                item.simple_res = (diff[32] != diff[31]) ? (diff[32] ? SAT_MIN : SAT_MAX)
                                                         : diff[31:0];
                item.status     = (diff[32] != diff[31]) ? ST_OVF : ST_OK;
            end
            OP_INC:  begin
                item.simple_res = (incv[32] != incv[31]) ? SAT_MAX : incv[31:0];
                item.status     = (incv[32] != incv[31]) ? ST_OVF : ST_OK;
            end
            OP_DEC:  begin
                item.simple_res = (decv[32] != decv[31]) ? SAT_MIN : decv[31:0];
                item.status     = (decv[32] != decv[31]) ? ST_OVF : ST_OK;
            end
            OP_TO_INT: item.simple_res = 32'(a_s >>> FRAC_BITS);
            OP_FROM_INT: begin
                if (shl > 64'sh0000_0000_7fff_ffff) begin
                    item.simple_res = SAT_MAX;
                    item.status     = ST_OVF;
                end else if (shl < -64'sh0000_0000_8000_0000) begin
                    item.simple_res = SAT_MIN;
                    item.status     = ST_OVF;
                end else begin
                    item.simple_res = shl[31:0];
                end
            end
            OP_DIV:  item.status = (b_in == 32'd0) ? ST_DIV0 : ST_OK;
            OP_EQ:   item.cmp = a_s == b_s;
            OP_NE:   item.cmp = a_s != b_s;
            OP_GE:   item.cmp = a_s >= b_s;
            OP_LE:   item.cmp = a_s <= b_s;
            OP_GT:   item.cmp = a_s > b_s;
            OP_LT:   item.cmp = a_s < b_s;
            default: item.cmp = 1'b0;
        endcase
    end

endmodule
`default_nettype wire

@@ design/fpa_div_step.sv @@
// one restoring division step: brings in a numerator bit, yields a quotient bit
`timescale 1ns / 1ps
`default_nettype none
module fpa_div_step (
    input  fpa_pkg::pipe_t item_in,
    output fpa_pkg::pipe_t item_out
);
    import fpa_pkg::*;

    logic [32:0] trial;
    logic        fits;

    assign trial = {item_in.rem[31:0], item_in.num_lo[31]};
    assign fits  = trial >= {1'b0, item_in.dvs};

    // subtract when the divisor fits, shift quotient bit in
    always_comb begin
        item_out        = item_in;
        item_out.rem    = fits ? trial - {1'b0, item_in.dvs} : trial;
        item_out.num_lo = {item_in.num_lo[30:0], 1'b0};
        item_out.quo    = {item_in.quo[30:0], fits};
    end

endmodule
`default_nettype wire

@@ design/fpa_finish.sv @@
// last stage: rounding and saturation for multiply and divide, result select
`timescale 1ns / 1ps
`default_nettype none
module fpa_finish #(
    parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
    input  fpa_pkg::pipe_t    item,
    output logic [31:0]       result,
    output logic              compare_true,
    output fpa_pkg::status_t  status
);
    import fpa_pkg::*;

    localparam logic [63:0] HALF = 64'd1 << (FRAC_BITS - 1);

    logic [63:0] pmag;
    logic [63:0] pround;
    logic        up;
    logic [63:0] qround;
    sat_t        mul_sat;
    sat_t        div_sat;

    // multiply: magnitude, round half away from zero
    assign pmag    = item.prod[63] ? 64'd0 - item.prod : item.prod;
    assign pround  = (pmag + HALF) >> FRAC_BITS;
    assign mul_sat = sat_mag(item.prod[63], pround);

    // divide: round up when twice the remainder reaches the divisor
    assign up      = {item.rem[31:0], 1'b0} >= {1'b0, item.dvs};
    assign qround  = item.dovf ? 64'h0000_0001_0000_0000
                               : {32'd0, item.quo} + {63'd0, up};
    assign div_sat = sat_mag(item.neg, qround);

    always_comb begin
        result       = item.simple_res;
        compare_true = item.cmp;
        status       = item.status;
        if (item.kind == OP_MUL) begin
            result = mul_sat.value;
            status = mul_sat.ovf ? ST_OVF : ST_OK;
        end else if (item.kind == OP_DIV && item.status != ST_DIV0) begin
            result = div_sat.value;
            status = div_sat.ovf ? ST_OVF : ST_OK;
        end
    end

endmodule
`default_nettype wire

@@ design/fixed_point_alu.sv @@
// top level of the pipelined signed fixed-point alu
// A signed fixed-point ALU (FRAC_BITS fraction bits, Q24.8 by default) taking
// one transaction per cycle and returning one result per transaction, in
// order. The path is one setup stage with the 32x32 multiplier, 32 restoring
// division stages at one quotient bit each, and a rounding/saturation stage
// that feeds the output register. Every op travels the same path, so results
// never reorder. When m_tready is low while the output register holds a
// result, the whole pipeline holds and s_tready drops with it.
`timescale 1ns / 1ps
`default_nettype none
module fixed_point_alu #(
    parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // operand_a [31:0], operand_b [63:32]
    input  wire logic [3:0]  s_tuser,   // op [3:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata    // result [31:0], compare_true [32], status [34:33]
);
    import fpa_pkg::*;

    localparam int NSTAGE = DIV_STEPS + 1;

    pipe_t       prep_item;
    pipe_t       pipe_reg  [NSTAGE];
    pipe_t       step_next [DIV_STEPS];
    logic        valid_reg [NSTAGE];
    logic        adv;
    logic [31:0] fin_result;
    logic        fin_cmp;
    status_t     fin_status;
    logic [31:0] result_reg;
    logic        cmp_reg;
    status_t     status_reg;
    logic        out_valid_reg;

    // whole pipeline moves when the output slot is free or being taken
    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;

    fpa_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
        .op_in (s_tuser),
        .a_in  (s_tdata[31:0]),
        .b_in  (s_tdata[63:32]),
        .item  (prep_item)
    );

    genvar g;
    generate
        for (g = 0; g < DIV_STEPS; g++) begin : g_div
            fpa_div_step u_step (
                .item_in  (pipe_reg[g]),
                .item_out (step_next[g])
            );
        end
    endgenerate

    fpa_finish #(.FRAC_BITS(FRAC_BITS)) u_finish (
        .item         (pipe_reg[NSTAGE-1]),
        .result       (fin_result),
        .compare_true (fin_cmp),
        .status       (fin_status)
    );

    // payload stages
    always_ff @(posedge aclk) begin
        if (adv) begin
            pipe_reg[0] <= prep_item;
            for (int i = 0; i < DIV_STEPS; i++) begin
                pipe_reg[i+1] <= step_next[i];
            end
            result_reg <= fin_result;
            cmp_reg    <= fin_cmp;
            status_reg <= fin_status;
        end
    end

    // valid bits travel with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NSTAGE; i++) begin
                valid_reg[i] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg[0] <= s_tvalid;
            for (int i = 1; i < NSTAGE; i++) begin
                valid_reg[i] <= valid_reg[i-1];
            end
            out_valid_reg <= valid_reg[NSTAGE-1];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, status_reg, cmp_reg, result_reg};

    // a true comparison carries no result and no error
    a_cmp_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && cmp_reg |-> result_reg == 32'd0 && status_reg == ST_OK)
        else $error("comparison transaction with nonzero result or status");

    // divide by zero always returns zero
    a_div0_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && status_reg == ST_DIV0 |-> result_reg == 32'd0 && !cmp_reg)
        else $error("divide by zero with nonzero result");

    // last pipeline stage stays put while the pipeline is stalled
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(valid_reg[NSTAGE-1]) && $stable(pipe_reg[NSTAGE-1]))
        else $error("pipeline moved during stall");

endmodule
`default_nettype wire
